// ----- rtl/core/bmq_pkg.sv -----
`default_nettype none

package bmq_pkg;

  // queue geometry
  localparam int NUM_QUEUES  = 4;
  localparam int QUEUE_DEPTH = 16;
  localparam int STORE_SIZE  = NUM_QUEUES * QUEUE_DEPTH;

  // derived widths
  localparam int QIDX_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int OFS_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W = $clog2(STORE_SIZE);
  localparam int DATA_W = 32;

  // request codes
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_DELETE = 1'b1;

  // status codes
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  typedef logic [NUM_QUEUES-1:0][OFS_W-1:0] ofs_vec_t;

  // queue choice handed from the selector to the top level
  typedef struct packed {
    logic [QIDX_W-1:0] ins_q;
    logic              ins_full;
    logic [OFS_W-1:0]  ins_wr_ofs;
    logic [QIDX_W-1:0] del_q;
    logic              del_empty;
    logic [OFS_W-1:0]  del_rd_ofs;
  } sel_t;

endpackage

`default_nettype wire

// ----- rtl/core/bmq_select.sv -----
`default_nettype none

module bmq_select (
  input  wire bmq_pkg::ofs_vec_t rd_ofs,
  input  wire bmq_pkg::ofs_vec_t wr_ofs,
  output bmq_pkg::sel_t          sel
);

  logic [bmq_pkg::NUM_QUEUES-1:0][bmq_pkg::OFS_W-1:0] fill;
  logic [bmq_pkg::QIDX_W-1:0] min_q;
  logic [bmq_pkg::QIDX_W-1:0] max_q;
  logic [bmq_pkg::OFS_W-1:0]  min_wr;
  logic [bmq_pkg::OFS_W-1:0]  max_rd;
  logic                       min_full;
  logic                       max_empty;

  // per-queue occupancy
  always_comb begin
    for (int i = 0; i < bmq_pkg::NUM_QUEUES; i++) begin
      fill[i] = wr_ofs[i] - rd_ofs[i];
    end
  end

  // emptiest and fullest queue, ties to the lowest index
  always_comb begin
    min_q = '0;
    max_q = '0;
    for (int i = 1; i < bmq_pkg::NUM_QUEUES; i++) begin
      if (fill[i] < fill[min_q]) begin
        min_q = bmq_pkg::QIDX_W'(i);
      end
      if (fill[i] > fill[max_q]) begin
        max_q = bmq_pkg::QIDX_W'(i);
      end
    end
  end

  // pick the offsets of the chosen queues through one-hot masks
  always_comb begin
    min_wr    = '0;
    max_rd    = '0;
    min_full  = 1'b0;
    max_empty = 1'b0;
    for (int i = 0; i < bmq_pkg::NUM_QUEUES; i++) begin
      if (min_q == bmq_pkg::QIDX_W'(i)) begin
        min_wr   = min_wr | wr_ofs[i];
        min_full = min_full | (wr_ofs[i] >= bmq_pkg::OFS_W'(bmq_pkg::QUEUE_DEPTH));
      end
      if (max_q == bmq_pkg::QIDX_W'(i)) begin
        max_rd    = max_rd | rd_ofs[i];
        max_empty = max_empty | (rd_ofs[i] == wr_ofs[i]);
      end
    end
  end

  assign sel.ins_q      = min_q;
  assign sel.ins_full   = min_full;
  assign sel.ins_wr_ofs = min_wr;
  assign sel.del_q      = max_q;
  assign sel.del_empty  = max_empty;
  assign sel.del_rd_ofs = max_rd;

endmodule

`default_nettype wire

// ----- rtl/core/bmq_store.sv -----
`default_nettype none

module bmq_store (
  input  wire                        clk,
  input  wire                        wr_en,
  input  wire [bmq_pkg::ADDR_W-1:0]  wr_addr,
  input  wire [bmq_pkg::DATA_W-1:0]  wr_data,
  input  wire                        rd_en,
  input  wire [bmq_pkg::ADDR_W-1:0]  rd_addr,
  output logic [bmq_pkg::DATA_W-1:0] rd_data
);

  logic [bmq_pkg::DATA_W-1:0] mem [bmq_pkg::STORE_SIZE];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/balanced_multi_queue.sv -----
// channel   ports                                        handshake
// input     in_req_type, in_value_in                     start && !busy
// result    out_status, out_queue_index, out_removed_value  out_valid, one cycle
//
// one transaction per cycle; its result shows in the cycle after acceptance
// the offset compare and update, plus one store port access, fit in that cycle
// the store read is registered, which is why the result waits for the next cycle
// busy stays low; the receiver cannot stall, so no result ever waits
// synchronous active-low reset empties every queue; the store is not cleared
`default_nettype none

module balanced_multi_queue (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               start,
  output logic                              busy,
  input  wire                               in_req_type,
  input  wire signed [bmq_pkg::DATA_W-1:0]  in_value_in,
  output logic                              out_valid,
  output logic [1:0]                        out_status,
  output logic [1:0]                        out_queue_index,
  output logic signed [bmq_pkg::DATA_W-1:0] out_removed_value
);

  bmq_pkg::ofs_vec_t rd_ofs_r, rd_ofs_nxt;
  bmq_pkg::ofs_vec_t wr_ofs_r, wr_ofs_nxt;
  bmq_pkg::sel_t     sel;

  logic                          accept;
  logic                          do_ins;
  logic                          do_del;
  logic [bmq_pkg::QIDX_W-1:0]    q_sel;
  logic [1:0]                    status_nxt;
  logic [bmq_pkg::ADDR_W-1:0]    wr_addr;
  logic [bmq_pkg::ADDR_W-1:0]    rd_addr;
  logic [bmq_pkg::DATA_W-1:0]    rd_data;

  logic                          valid_r;
  logic [1:0]                    status_r;
  logic [bmq_pkg::QIDX_W-1:0]    qidx_r;
  logic                          del_ok_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  bmq_select u_select (
    .rd_ofs (rd_ofs_r),
    .wr_ofs (wr_ofs_r),
    .sel    (sel)
  );

  // decide the operation for this transaction
  always_comb begin
    do_ins     = 1'b0;
    do_del     = 1'b0;
    status_nxt = bmq_pkg::ST_DONE;
    if (in_req_type == bmq_pkg::REQ_INSERT) begin
      q_sel = sel.ins_q;
      if (sel.ins_full) begin
        status_nxt = bmq_pkg::ST_OVERFLOW;
      end else begin
        do_ins = accept;
      end
    end else begin
      q_sel = sel.del_q;
      if (sel.del_empty) begin
        status_nxt = bmq_pkg::ST_UNDERFLOW;
      end else begin
        do_del = accept;
      end
    end
  end

  // store addresses: segment base plus offset
  assign wr_addr = bmq_pkg::ADDR_W'(
                     bmq_pkg::ADDR_W'(sel.ins_q) * bmq_pkg::ADDR_W'(bmq_pkg::QUEUE_DEPTH)
                     + bmq_pkg::ADDR_W'(sel.ins_wr_ofs));
  assign rd_addr = bmq_pkg::ADDR_W'(
                     bmq_pkg::ADDR_W'(sel.del_q) * bmq_pkg::ADDR_W'(bmq_pkg::QUEUE_DEPTH)
                     + bmq_pkg::ADDR_W'(sel.del_rd_ofs));

  bmq_store u_store (
    .clk     (clk),
    .wr_en   (do_ins),
    .wr_addr (wr_addr),
    .wr_data (in_value_in),
    .rd_en   (do_del),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // offset update for the chosen queue
  always_comb begin
    rd_ofs_nxt = rd_ofs_r;
    wr_ofs_nxt = wr_ofs_r;
    for (int i = 0; i < bmq_pkg::NUM_QUEUES; i++) begin
      if (do_ins && (sel.ins_q == bmq_pkg::QIDX_W'(i))) begin
        wr_ofs_nxt[i] = wr_ofs_r[i] + bmq_pkg::OFS_W'(1);
      end
      if (do_del && (sel.del_q == bmq_pkg::QIDX_W'(i))) begin
        rd_ofs_nxt[i] = rd_ofs_r[i] + bmq_pkg::OFS_W'(1);
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ofs_r <= '0;
      wr_ofs_r <= '0;
      valid_r  <= 1'b0;
      del_ok_r <= 1'b0;
    end else begin
      rd_ofs_r <= rd_ofs_nxt;
      wr_ofs_r <= wr_ofs_nxt;
      valid_r  <= accept;
      del_ok_r <= do_del;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      qidx_r   <= q_sel;
    end
  end

  assign out_valid         = valid_r;
  assign out_status        = status_r;
  assign out_queue_index   = 2'(qidx_r);
  assign out_removed_value = del_ok_r ? rd_data : '0;

endmodule

`default_nettype wire

// ----- rtl/core/bmq_checker.sv -----
`default_nettype none

module bmq_checker (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              start,
  input wire                              busy,
  input wire                              in_req_type,
  input wire                              out_valid,
  input wire [1:0]                        out_status,
  input wire [bmq_pkg::DATA_W-1:0]        out_removed_value
);

  // every accepted transaction gives a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("accepted transaction produced no result");

  // no result without an accepted transaction
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> !out_valid)
    else $error("result without a transaction");

  // an insert never reports underflow, a delete never overflow
  a_status_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ((out_status == bmq_pkg::ST_DONE) ||
      ($past(in_req_type) == bmq_pkg::REQ_INSERT && out_status == bmq_pkg::ST_OVERFLOW) ||
      ($past(in_req_type) == bmq_pkg::REQ_DELETE && out_status == bmq_pkg::ST_UNDERFLOW)))
    else $error("status does not match request kind");

  // removed value is zero after an accepted insert
  a_removed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ((start && !busy) && in_req_type == bmq_pkg::REQ_INSERT) |=> (out_removed_value == '0))
    else $error("insert reported a removed value");

endmodule

bind balanced_multi_queue bmq_checker u_bmq_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .in_req_type       (in_req_type),
  .out_valid         (out_valid),
  .out_status        (out_status),
  .out_removed_value (out_removed_value)
);

`default_nettype wire
